/* src/tkl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_pkg: shared types and constants of the top-K leaderboard
// Table size, field widths, slot and result records, and the signed key
// compare used by the sequencer.
// ----------------------------------------------------------------------------
package tkl_pkg;

    localparam int TABLE_SIZE = 10;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int SCORE_W    = 32;
    localparam int GROUP_W    = 8;
    localparam int ID_W       = 16;
    localparam int RANK_W     = 4;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [GROUP_W-1:0] grp;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef struct packed {
        entry_t ent;
        logic   used;
    } slot_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        entry_t            ent;
        logic              filled;
        logic              final_res;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

    function automatic logic key_less(input logic [SCORE_W-1:0] a,
                                      input logic [SCORE_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // An unused slot reads as all zeros, whatever the memory holds.
    function automatic slot_t masked(input entry_t e, input logic used);
        slot_t s;
        s.ent  = used ? e : '0;
        s.used = used;
        return s;
    endfunction

endpackage

/* src/tkl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_ram: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tkl_ram (
    input  logic                           aclk,
    input  tkl_pkg::ram_wr_t               wr,
    input  logic [tkl_pkg::IDX_W-1:0]      raddr,
    output tkl_pkg::entry_t                rdata
);

    tkl_pkg::entry_t mem [tkl_pkg::TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/tkl_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_seq: leaderboard sequencer
// Takes one request, finds its target slot with a single key comparator,
// updates the table, and on the last request of a batch runs the exchange
// sort and reads the table out rank by rank.
// ----------------------------------------------------------------------------
module tkl_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tkl_pkg::SCORE_W-1:0]     s_score,
    input  logic [tkl_pkg::GROUP_W-1:0]     s_group,
    input  logic [tkl_pkg::ID_W-1:0]        s_entry_id,
    input  logic                            s_first,
    input  logic                            s_last,
    input  logic                            out_busy,
    output logic                            res_load,
    output tkl_pkg::result_t                res,
    output tkl_pkg::ram_wr_t                ram_wr,
    output logic [tkl_pkg::IDX_W-1:0]       ram_raddr,
    input  tkl_pkg::entry_t                 ram_rdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PICK = 4'd1;
    localparam logic [3:0] ST_SCAN = 4'd2;
    localparam logic [3:0] ST_UPD  = 4'd3;
    localparam logic [3:0] ST_SLD  = 4'd4;
    localparam logic [3:0] ST_SLW  = 4'd5;
    localparam logic [3:0] ST_SJ   = 4'd6;
    localparam logic [3:0] ST_SWB  = 4'd7;
    localparam logic [3:0] ST_ER   = 4'd8;
    localparam logic [3:0] ST_ED   = 4'd9;

    localparam logic [tkl_pkg::CNT_W-1:0] CNT_END  = tkl_pkg::CNT_W'(tkl_pkg::TABLE_SIZE);
    localparam logic [tkl_pkg::CNT_W-1:0] CNT_LAST = tkl_pkg::CNT_W'(tkl_pkg::TABLE_SIZE - 1);
    localparam logic [tkl_pkg::IDX_W-1:0] SI_LAST  = tkl_pkg::IDX_W'(tkl_pkg::TABLE_SIZE - 2);

    logic [3:0]                        state_reg, state_next;
    logic [tkl_pkg::TABLE_SIZE-1:0]    used_reg, used_next;
    logic [tkl_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [tkl_pkg::IDX_W-1:0]         pidx_reg, pidx_next;
    logic                              pend_reg, pend_next;
    logic [tkl_pkg::IDX_W-1:0]         si_reg, si_next;
    logic [tkl_pkg::IDX_W-1:0]         best_reg, best_next;
    logic [tkl_pkg::SCORE_W-1:0]       best_key_reg, best_key_next;
    tkl_pkg::entry_t                   item_reg, item_next;
    logic                              last_reg, last_next;
    tkl_pkg::slot_t                    hold_reg, hold_next;

    logic [tkl_pkg::IDX_W-1:0]         fe_idx;
    tkl_pkg::slot_t                    rd_slot;
    tkl_pkg::slot_t                    out_slot;
    logic [tkl_pkg::IDX_W-1:0]         cnt_idx;
    logic [tkl_pkg::SCORE_W-1:0]       cmp_a;
    logic [tkl_pkg::SCORE_W-1:0]       cmp_b;
    logic                              key_lt;

    assign cnt_idx  = cnt_reg[tkl_pkg::IDX_W-1:0];
    assign rd_slot  = tkl_pkg::masked(ram_rdata, used_reg[pidx_reg]);
    assign out_slot = tkl_pkg::masked(ram_rdata, used_reg[cnt_idx]);
    assign s_ready  = (state_reg == ST_IDLE);

    // One comparator serves the scan, the update and the sort.
    always_comb begin
        case (state_reg)
            ST_SCAN: begin
                cmp_a = rd_slot.ent.score;
                cmp_b = best_key_reg;
            end
            ST_SJ: begin
                cmp_a = hold_reg.ent.score;
                cmp_b = rd_slot.ent.score;
            end
            default: begin
                cmp_a = best_key_reg;
                cmp_b = item_reg.score;
            end
        endcase
    end

    assign key_lt = tkl_pkg::key_less(cmp_a, cmp_b);

    // Lowest-numbered empty slot.
    always_comb begin
        fe_idx = '0;
        for (int i = tkl_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                fe_idx = tkl_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        cnt_next      = cnt_reg;
        pidx_next     = pidx_reg;
        pend_next     = pend_reg;
        si_next       = si_reg;
        best_next     = best_reg;
        best_key_next = best_key_reg;
        item_next     = item_reg;
        last_next     = last_reg;
        hold_next     = hold_reg;
        ram_wr        = '0;
        ram_raddr     = cnt_idx;
        res_load      = 1'b0;
        res.rank      = tkl_pkg::RANK_W'(cnt_reg);
        res.ent       = out_slot.ent;
        res.filled    = out_slot.used;
        res.final_res = (cnt_reg == CNT_LAST);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next.score = s_score;
                    item_next.grp   = s_group;
                    item_next.id    = s_entry_id;
                    last_next       = s_last;
                    if (s_first) begin
                        used_next = '0;
                    end
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (!(&used_reg)) begin
                    best_next     = fe_idx;
                    best_key_next = '0;
                    state_next    = ST_UPD;
                end else begin
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Reads are issued one slot ahead of the compare.
                if (pend_reg) begin
                    if (pidx_reg == '0 || key_lt) begin
                        best_next     = pidx_reg;
                        best_key_next = rd_slot.ent.score;
                    end
                end
                if (cnt_reg == CNT_END) begin
                    pend_next  = 1'b0;
                    state_next = ST_UPD;
                end else begin
                    pidx_next = cnt_idx;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_UPD: begin
                if (key_lt) begin
                    ram_wr.en           = 1'b1;
                    ram_wr.addr         = best_reg;
                    ram_wr.data         = item_reg;
                    used_next[best_reg] = 1'b1;
                end
                if (last_reg) begin
                    si_next    = '0;
                    state_next = ST_SLD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SLD: begin
                ram_raddr  = si_reg;
                pidx_next  = si_reg;
                state_next = ST_SLW;
            end
            ST_SLW: begin
                hold_next  = rd_slot;
                cnt_next   = tkl_pkg::CNT_W'(si_reg) + 1'b1;
                pend_next  = 1'b0;
                state_next = ST_SJ;
            end
            ST_SJ: begin
                // The slot being placed stays in hold_reg; a larger key in
                // slot j trades places with it.
                if (pend_reg && key_lt) begin
                    ram_wr.en           = 1'b1;
                    ram_wr.addr         = pidx_reg;
                    ram_wr.data         = hold_reg.ent;
                    used_next[pidx_reg] = hold_reg.used;
                    hold_next           = rd_slot;
                end
                if (cnt_reg == CNT_END) begin
                    pend_next  = 1'b0;
                    state_next = ST_SWB;
                end else begin
                    pidx_next = cnt_idx;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_SWB: begin
                ram_wr.en         = 1'b1;
                ram_wr.addr       = si_reg;
                ram_wr.data       = hold_reg.ent;
                used_next[si_reg] = hold_reg.used;
                if (si_reg == SI_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_ER;
                end else begin
                    si_next    = si_reg + 1'b1;
                    state_next = ST_SLD;
                end
            end
            ST_ER: begin
                if (!out_busy) begin
                    state_next = ST_ED;
                end
            end
            ST_ED: begin
                res_load = 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_ER;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            si_reg    <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            si_reg    <= si_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg     <= pidx_next;
        best_reg     <= best_next;
        best_key_reg <= best_key_next;
        item_reg     <= item_next;
        last_reg     <= last_next;
        hold_reg     <= hold_next;
    end

endmodule

/* src/top_k_leaderboard_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_leaderboard_top: top-K leaderboard
// Keeps the highest-scoring entries of a batch and emits them sorted.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds the TABLE_SIZE best
// entries of the current batch in a small memory with one read and one write
// port plus a row of slot-used flags. While the table has an empty slot a
// request goes straight to its update; once it is full, the request first
// scans the memory through one read port and one key comparator. A request
// with last adds the exchange sort and then the read-out of the results,
// which waits while a stalled result holds the output register; a result
// waits in an output register, so the next request is taken while the last
// result is pending.
// ----------------------------------------------------------------------------
module top_k_leaderboard_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [tkl_pkg::SCORE_W-1:0] s_score,
    input  logic [tkl_pkg::GROUP_W-1:0]     s_group,
    input  logic [tkl_pkg::ID_W-1:0]        s_entry_id,
    input  logic                            s_first,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tkl_pkg::RANK_W-1:0]      m_rank,
    output logic signed [tkl_pkg::SCORE_W-1:0] m_out_score,
    output logic [tkl_pkg::GROUP_W-1:0]     m_out_group,
    output logic [tkl_pkg::ID_W-1:0]        m_out_id,
    output logic                            m_filled,
    output logic                            m_final_res
);

    tkl_pkg::ram_wr_t              ram_wr;
    logic [tkl_pkg::IDX_W-1:0]     ram_raddr;
    tkl_pkg::entry_t               ram_rdata;
    tkl_pkg::result_t              res;
    logic                          res_load;
    logic                          out_busy;
    logic                          m_valid_reg, m_valid_next;
    tkl_pkg::result_t              res_reg;

    tkl_ram u_ram (
        .aclk  (aclk),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tkl_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_score    (s_score),
        .s_group    (s_group),
        .s_entry_id (s_entry_id),
        .s_first    (s_first),
        .s_last     (s_last),
        .out_busy   (out_busy),
        .res_load   (res_load),
        .res        (res),
        .ram_wr     (ram_wr),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // The register is free at the next edge unless it holds a stalled result.
    assign out_busy = m_valid_reg && !m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rank      = res_reg.rank;
    assign m_out_score = res_reg.ent.score;
    assign m_out_group = res_reg.ent.grp;
    assign m_out_id    = res_reg.ent.id;
    assign m_filled    = res_reg.filled;
    assign m_final_res = res_reg.final_res;

endmodule

/* sim/tkl_rank_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_rank_checker: result checker for the top-K leaderboard
// Watches both channels. It keeps its own copy of the slot table, updates it
// for every accepted request, and on a batch end queues the sorted ranks that
// the block has to emit. Each emitted rank is compared field by field with
// the oldest queued one.
// ----------------------------------------------------------------------------
module tkl_rank_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [tkl_pkg::SCORE_W-1:0]   s_score,
    input  logic [tkl_pkg::GROUP_W-1:0]   s_group,
    input  logic [tkl_pkg::ID_W-1:0]      s_entry_id,
    input  logic                          s_first,
    input  logic                          s_last,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [tkl_pkg::RANK_W-1:0]    m_rank,
    input  logic [tkl_pkg::SCORE_W-1:0]   m_out_score,
    input  logic [tkl_pkg::GROUP_W-1:0]   m_out_group,
    input  logic [tkl_pkg::ID_W-1:0]      m_out_id,
    input  logic                          m_filled,
    input  logic                          m_final_res,
    output int                            fail_count,
    output int                            results_pending
);
    import tkl_pkg::*;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [GROUP_W-1:0] grp;
        logic [ID_W-1:0]    id;
        logic               used;
    } board_slot_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [SCORE_W-1:0] score;
        logic [GROUP_W-1:0] grp;
        logic [ID_W-1:0]    id;
        logic               filled;
        logic               final_res;
    } ranked_entry_t;

    board_slot_t   board [TABLE_SIZE];
    ranked_entry_t ranked_q [$];
    int            err_cnt = 0;

    task automatic clear_board();
        int i;
        for (i = 0; i < TABLE_SIZE; i++) begin
            board[i] = '0;
        end
    endtask

    // Applies one request to the table and, on a batch end, queues the ranks.
    task automatic take_entry(input logic [SCORE_W-1:0] score,
                              input logic [GROUP_W-1:0] grp,
                              input logic [ID_W-1:0]    id,
                              input logic               first,
                              input logic               last);
        int            i;
        int            j;
        int            tgt;
        bit            found;
        board_slot_t   tmp;
        ranked_entry_t r;
        if (first) begin
            clear_board();
        end
        tgt   = 0;
        found = 1'b0;
        for (i = 0; i < TABLE_SIZE; i++) begin
            if (!found && !board[i].used) begin
                tgt   = i;
                found = 1'b1;
            end
        end
        // With no free slot the target is the first slot holding the minimum.
        if (!found) begin
            for (i = 1; i < TABLE_SIZE; i++) begin
                if ($signed(board[i].score) < $signed(board[tgt].score)) begin
                    tgt = i;
                end
            end
        end
        // Empty slots hold a zero key, so non-positive scores never land.
        if ($signed(board[tgt].score) < $signed(score)) begin
            board[tgt] = '{score: score, grp: grp, id: id, used: 1'b1};
        end
        if (last) begin
            for (i = 0; i < TABLE_SIZE; i++) begin
                for (j = i + 1; j < TABLE_SIZE; j++) begin
                    if ($signed(board[i].score) < $signed(board[j].score)) begin
                        tmp      = board[i];
                        board[i] = board[j];
                        board[j] = tmp;
                    end
                end
            end
            for (i = 0; i < TABLE_SIZE; i++) begin
                r.rank      = RANK_W'(i);
                r.score     = board[i].score;
                r.grp       = board[i].grp;
                r.id        = board[i].id;
                r.filled    = board[i].used;
                r.final_res = (i == TABLE_SIZE - 1);
                ranked_q.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin : watch
        ranked_entry_t want;
        if (!aresetn) begin
            clear_board();
            ranked_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (ranked_q.size() == 0) begin
                    $error("unexpected result at rank %0d", m_rank);
                    err_cnt++;
                end else begin
                    want = ranked_q.pop_front();
                    check_field("rank", 32'(want.rank), 32'(m_rank));
                    check_field("out_score", want.score, m_out_score);
                    check_field("out_group", 32'(want.grp), 32'(m_out_group));
                    check_field("out_id", 32'(want.id), 32'(m_out_id));
                    check_field("filled", 32'(want.filled), 32'(m_filled));
                    check_field("final_res", 32'(want.final_res), 32'(m_final_res));
                end
            end
            if (s_valid && s_ready) begin
                take_entry(s_score, s_group, s_entry_id, s_first, s_last);
            end
        end
        fail_count      <= err_cnt;
        results_pending <= ranked_q.size();
    end

endmodule

/* sim/tb_top_k_leaderboard_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_leaderboard_top: testbench of the top-K leaderboard
// Sends a directed set of batches covering extreme scores, empty and
// duplicate keys, replacement in a full table and entries before any clear,
// then random batches under three idling patterns on both channels. The
// checker beside the block predicts and compares every emitted rank.
// ----------------------------------------------------------------------------
module tb_top_k_leaderboard_top;
    import tkl_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 43;
    localparam int SETTLE_CYCLES = 150;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [SCORE_W-1:0] s_score;
    logic [GROUP_W-1:0]        s_group;
    logic [ID_W-1:0]           s_entry_id;
    logic                      s_first;
    logic                      s_last;
    logic                      m_valid;
    logic                      m_ready;
    logic [RANK_W-1:0]         m_rank;
    logic signed [SCORE_W-1:0] m_out_score;
    logic [GROUP_W-1:0]        m_out_group;
    logic [ID_W-1:0]           m_out_id;
    logic                      m_filled;
    logic                      m_final_res;

    int fail_count;
    int results_pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    top_k_leaderboard_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_score     (s_score),
        .s_group     (s_group),
        .s_entry_id  (s_entry_id),
        .s_first     (s_first),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rank      (m_rank),
        .m_out_score (m_out_score),
        .m_out_group (m_out_group),
        .m_out_id    (m_out_id),
        .m_filled    (m_filled),
        .m_final_res (m_final_res)
    );

    tkl_rank_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_score         (s_score),
        .s_group         (s_group),
        .s_entry_id      (s_entry_id),
        .s_first         (s_first),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rank          (m_rank),
        .m_out_score     (m_out_score),
        .m_out_group     (m_out_group),
        .m_out_id        (m_out_id),
        .m_filled        (m_filled),
        .m_final_res     (m_final_res),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Ends the run when neither channel has moved anything for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid is only lowered for an idle cycle, so back-to-back requests keep
    // it high without a second assignment in the same step.
    task automatic send_entry(input logic [SCORE_W-1:0] score,
                              input logic [GROUP_W-1:0] grp,
                              input logic [ID_W-1:0]    id,
                              input logic               first,
                              input logic               last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_score    <= score;
        s_group    <= grp;
        s_entry_id <= id;
        s_first    <= first;
        s_last     <= last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(1, 8);
            2: return ~$urandom_range(0, 1000);
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'h1;
                endcase
            end
            default: return $urandom() & 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 19))
            0: return 16'h0001;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        int dup_scores [14];
        int phase;
        int sent;
        int len;
        int mode;
        int k;
        logic first;
        logic last;

        dup_scores = '{50, 50, 20, 20, 30, 10, 40, 10, 60, 5, 10, 50, 3, 70};
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_score    <= '0;
        s_group    <= '0;
        s_entry_id <= '0;
        s_first    <= 1'b0;
        s_last     <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An entry before any clear goes into the empty table left by reset;
        // a negative entry that ends the batch is dropped.
        send_entry(32'd100, 8'd1, 16'd1, 1'b0, 1'b0);
        send_entry(32'hFFFF_FFFF, 8'd2, 16'd2, 1'b0, 1'b1);
        // One-request batch at the top of the key range.
        send_entry(32'h7FFF_FFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
        // The most negative key and zero are never stored, an id of zero is.
        send_entry(32'h8000_0000, 8'hAA, 16'h5555, 1'b1, 1'b0);
        send_entry(32'h0, 8'h55, 16'hAAAA, 1'b0, 1'b0);
        send_entry(32'd7, 8'h0F, 16'h0, 1'b0, 1'b0);
        // Overfill with duplicate keys to exercise replacement and ties.
        for (k = 0; k < 14; k++) begin
            send_entry(dup_scores[k], 8'(k + 16), 16'(k + 100), 1'b0, 1'b0);
        end
        send_entry(32'd50, 8'hF0, 16'h8000, 1'b0, 1'b1);
        wait_for_drain();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 75;
                end
                1: begin
                    tx_idle_pct = 75;
                    rx_idle_pct = 27;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len  = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24)
                                                   : $urandom_range(1, 12);
                // Mostly clean batches; some continue the previous table, some
                // clear it midway and some never close.
                mode = $urandom_range(0, 9);
                for (k = 0; k < len; k++) begin
                    if (k == 0) begin
                        first = (mode != 0);
                    end else begin
                        first = (mode == 1) && ($urandom_range(0, 4) == 0);
                    end
                    last = (k == len - 1) && (mode != 2);
                    send_entry(pick_score(), 8'($urandom_range(0, 255)), pick_id(),
                               first, last);
                end
                sent += len;
                if ($urandom_range(0, 7) == 0) begin
                    wait_for_drain();
                end
            end
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
